// File: rtl/three_tone_sine_synthesizer_unit_macros.svh
// Assertion macros used by the three-tone synthesizer top level
`ifndef THREE_TONE_SINE_SYNTHESIZER_UNIT_MACROS_SVH
`define THREE_TONE_SINE_SYNTHESIZER_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define TTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define TTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tts_pkg.sv
// Constants, types and sine table builder for the three-tone synthesizer
`default_nettype none
package tts_pkg;

   localparam int PHASE_BITS     = 32;
   localparam int ADDR_BITS      = 10;
   localparam int QUARTER_BITS   = ADDR_BITS - 2;
   localparam int QUARTER        = 1 << QUARTER_BITS;
   localparam int SINE_MAG_BITS  = 15;
   localparam int AMP_BITS       = 15;
   localparam int FREQ_BITS      = 32;
   localparam int SAMPLE_BITS    = 16;
   localparam int SUM_BITS       = SAMPLE_BITS + 2;
   localparam int NUM_TONES      = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [FREQ_BITS-1:0] FREQ_ONE_RESET   = 32'd42852281;
   localparam logic [FREQ_BITS-1:0] FREQ_TWO_RESET   = 32'd21426141;
   localparam logic [FREQ_BITS-1:0] FREQ_THREE_RESET = 32'd32139211;
   localparam logic [AMP_BITS-1:0]  AMP_ONE_RESET    = 15'd10000;
   localparam logic [AMP_BITS-1:0]  AMP_TWO_RESET    = 15'd5000;
   localparam logic [AMP_BITS-1:0]  AMP_THREE_RESET  = 15'd7500;

   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FREQ_ONE   = 3'd0,
      CSR_FREQ_TWO   = 3'd1,
      CSR_FREQ_THREE = 3'd2,
      CSR_AMP_ONE    = 3'd3,
      CSR_AMP_TWO    = 3'd4,
      CSR_AMP_THREE  = 3'd5
   } csr_index_type;

   // pipeline load strobes handed to each tone path
   typedef struct packed {
      logic s1_load;
      logic s2_load;
   } tts_adv_type;

   typedef logic [SINE_MAG_BITS-1:0] quarter_table_type [QUARTER];

   // one step of the Horner series: t = 1 - x2 * t / div, floored at zero
   function automatic logic [63:0] horner_step(input logic [63:0] d);
      return (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
   endfunction

   // sin(x) for x in Q2.30 on the first quarter wave
   function automatic logic [63:0] quarter_sine_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = horner_step(((x2 * t) >> 30) / 156);
      t  = horner_step(((x2 * t) >> 30) / 110);
      t  = horner_step(((x2 * t) >> 30) / 72);
      t  = horner_step(((x2 * t) >> 30) / 42);
      t  = horner_step(((x2 * t) >> 30) / 20);
      t  = horner_step(((x2 * t) >> 30) / 6);
      return (x * t) >> 30;
   endfunction

   // Q0.15 magnitude of the sine at quarter-wave position q (0..QUARTER)
   function automatic logic [SINE_MAG_BITS-1:0] sine_magnitude(input int q);
      logic [63:0] x;
      logic [63:0] s;
      logic [63:0] m;
      x = (64'(q) * HALF_PI_Q30) >> QUARTER_BITS;
      s = quarter_sine_q30(x);
      m = (s * 64'd32768 + (64'd1 << 29)) >> 30;
      if (m > 64'd32767) begin
         m = 64'd32767;
      end
      return m[SINE_MAG_BITS-1:0];
   endfunction

   function automatic quarter_table_type build_quarter_table();
      quarter_table_type tbl;
      for (int k = 0; k < QUARTER; k++) begin
         tbl[k] = sine_magnitude(k);
      end
      return tbl;
   endfunction

   localparam quarter_table_type SINE_QUARTER = build_quarter_table();
   localparam logic [SINE_MAG_BITS-1:0] SINE_PEAK = sine_magnitude(QUARTER);

endpackage
`default_nettype wire

// File: rtl/tts_req_if.sv
// Request channel interface: one tick word with the restart flag
`default_nettype none
interface tts_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface
`default_nettype wire

// File: rtl/tts_rsp_if.sv
// Response channel interface: three tone samples and their mix
`default_nettype none
interface tts_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] tone_one_sample;
   logic signed [15:0] tone_two_sample;
   logic signed [15:0] tone_three_sample;
   logic signed [15:0] mixed_sample;

   modport source (output valid, output tone_one_sample, output tone_two_sample,
                   output tone_three_sample, output mixed_sample, input ready);
   modport sink   (input valid, input tone_one_sample, input tone_two_sample,
                   input tone_three_sample, input mixed_sample, output ready);
endinterface
`default_nettype wire

// File: rtl/three_tone_sine_synthesizer_unit.sv
// Top level of the three-tone sine synthesizer: registers, phases and mixing
//
//  channel  | direction | word contents
//  ---------+-----------+----------------------------------------------
//  req_bus  | in        | restart flag, one word per audio sample
//  rsp_bus  | out       | three tone samples and their saturated mix
//  csr_*    | in        | write-only tone frequency and amplitude regs
//
// One word is accepted every cycle while the lookup stage can advance; its
// result word passes the lookup and amplitude multiply registers, then is
// mixed and saturated into the output register: up to three words in flight.
// Synchronous active-high reset clears the phases and pipeline valids and
// loads the register defaults. A stalled response holds only as far back as
// it must: empty stages upstream keep taking words.
`default_nettype none
`include "three_tone_sine_synthesizer_unit_macros.svh"
module three_tone_sine_synthesizer_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   tts_req_if.sink                                  req_bus,
   tts_rsp_if.source                                rsp_bus,
   input  wire logic                                csr_wr_en,
   input  wire logic [tts_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [tts_pkg::CSR_DATA_BITS-1:0]   csr_wr_data
);
   import tts_pkg::*;

   logic [FREQ_BITS-1:0]  freq_ff  [NUM_TONES];
   logic [FREQ_BITS-1:0]  freq_in  [NUM_TONES];
   logic [AMP_BITS-1:0]   amp_ff   [NUM_TONES];
   logic [AMP_BITS-1:0]   amp_in   [NUM_TONES];
   logic [PHASE_BITS-1:0] phase_ff [NUM_TONES];
   logic [PHASE_BITS-1:0] phase_in [NUM_TONES];
   logic [PHASE_BITS-1:0] phase_cur [NUM_TONES];

   logic signed [SAMPLE_BITS-1:0] tone [NUM_TONES];

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_adv, s2_adv, s1_adv, accept, out_load;
   tts_adv_type adv;

   logic signed [SUM_BITS-1:0]    mix_sum;
   logic signed [SAMPLE_BITS-1:0] mix_sat;
   logic signed [SAMPLE_BITS-1:0] t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in;
   logic signed [SAMPLE_BITS-1:0] mix_ff, mix_in;

   // stage advance: move when the next stage is empty or moving
   always_comb begin
      out_adv     = !rsp_valid_ff || rsp_bus.ready;
      s2_adv      = !s2_valid_ff || out_adv;
      s1_adv      = !s1_valid_ff || s2_adv;
      accept      = req_bus.valid && s1_adv;
      out_load    = out_adv && s2_valid_ff;
      adv.s1_load = accept;
      adv.s2_load = s2_adv && s1_valid_ff;
      s1_valid_in  = s1_adv ? accept : s1_valid_ff;
      s2_valid_in  = s2_adv ? s1_valid_ff : s2_valid_ff;
      rsp_valid_in = out_adv ? s2_valid_ff : rsp_valid_ff;
   end

   assign req_bus.ready = s1_adv;

   // register writes
   always_comb begin
      freq_in = freq_ff;
      amp_in  = amp_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_FREQ_ONE:   freq_in[0] = csr_wr_data[FREQ_BITS-1:0];
            CSR_FREQ_TWO:   freq_in[1] = csr_wr_data[FREQ_BITS-1:0];
            CSR_FREQ_THREE: freq_in[2] = csr_wr_data[FREQ_BITS-1:0];
            CSR_AMP_ONE:    amp_in[0]  = csr_wr_data[AMP_BITS-1:0];
            CSR_AMP_TWO:    amp_in[1]  = csr_wr_data[AMP_BITS-1:0];
            CSR_AMP_THREE:  amp_in[2]  = csr_wr_data[AMP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // phase accumulators: sample at the current phase, then advance
   always_comb begin
      for (int t = 0; t < NUM_TONES; t++) begin
         phase_cur[t] = req_bus.restart ? '0 : phase_ff[t];
         phase_in[t]  = accept ? phase_cur[t] + PHASE_BITS'(freq_ff[t]) : phase_ff[t];
      end
   end

   for (genvar g = 0; g < NUM_TONES; g++) begin : g_tone
      tts_tone_path u_path (
         .clock       (clock),
         .adv         (adv),
         .phase       (phase_cur[g]),
         .amplitude   (amp_ff[g]),
         .tone_sample (tone[g])
      );
   end

   // mix and clamp to the 16-bit range
   always_comb begin
      mix_sum = SUM_BITS'(tone[0]) + SUM_BITS'(tone[1]) + SUM_BITS'(tone[2]);
      if (mix_sum > SUM_BITS'(32767)) begin
         mix_sat = 16'sh7FFF;
      end else if (mix_sum < -SUM_BITS'(32768)) begin
         mix_sat = -16'sh8000;
      end else begin
         mix_sat = mix_sum[SAMPLE_BITS-1:0];
      end
      t1_in  = out_load ? tone[0] : t1_ff;
      t2_in  = out_load ? tone[1] : t2_ff;
      t3_in  = out_load ? tone[2] : t3_ff;
      mix_in = out_load ? mix_sat : mix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff[0]   <= FREQ_ONE_RESET;
         freq_ff[1]   <= FREQ_TWO_RESET;
         freq_ff[2]   <= FREQ_THREE_RESET;
         amp_ff[0]    <= AMP_ONE_RESET;
         amp_ff[1]    <= AMP_TWO_RESET;
         amp_ff[2]    <= AMP_THREE_RESET;
         phase_ff     <= '{default: '0};
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         freq_ff      <= freq_in;
         amp_ff       <= amp_in;
         phase_ff     <= phase_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t1_ff  <= t1_in;
      t2_ff  <= t2_in;
      t3_ff  <= t3_in;
      mix_ff <= mix_in;
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.tone_one_sample   = t1_ff;
   assign rsp_bus.tone_two_sample   = t2_ff;
   assign rsp_bus.tone_three_sample = t3_ff;
   assign rsp_bus.mixed_sample      = mix_ff;

   `TTS_ASSERT_NEXT(a_restart_phase, accept && req_bus.restart,
      phase_ff[0] == PHASE_BITS'($past(freq_ff[0])), "restart did not reload phase")
   `TTS_ASSERT_NEXT(a_phase_hold, !accept, $stable(phase_ff[1]),
      "phase moved without an accepted word")
   `TTS_ASSERT_NOW(a_no_overrun, s1_valid_ff && !s2_adv, !accept,
      "word accepted over a blocked lookup stage")
   `TTS_ASSERT_NEXT(a_accept_fills, accept, s1_valid_ff,
      "accepted word missing from lookup stage")

endmodule
`default_nettype wire

// File: rtl/tts_tone_path.sv
// One tone: quarter-wave sine lookup, then amplitude scaling
`default_nettype none
module tts_tone_path (
   input  wire logic                                 clock,
   input  wire tts_pkg::tts_adv_type                 adv,
   input  wire logic [tts_pkg::PHASE_BITS-1:0]       phase,
   input  wire logic [tts_pkg::AMP_BITS-1:0]         amplitude,
   output logic signed [tts_pkg::SAMPLE_BITS-1:0]    tone_sample
);
   import tts_pkg::*;

   logic [ADDR_BITS-1:0]        addr;
   logic [1:0]                  quad;
   logic [QUARTER_BITS-1:0]     quarter_pos;
   logic [QUARTER_BITS-1:0]     quarter_idx;
   logic                        is_peak;
   logic [SINE_MAG_BITS-1:0]    sine_mag;
   logic [2*SINE_MAG_BITS-1:0]  product;

   logic                        neg1_ff, neg1_in;
   logic [SINE_MAG_BITS-1:0]    sine1_ff, sine1_in;
   logic                        neg2_ff, neg2_in;
   logic [SINE_MAG_BITS-1:0]    scaled2_ff, scaled2_in;

   // fold the phase into the first quarter wave
   always_comb begin
      addr        = phase[PHASE_BITS-1 -: ADDR_BITS];
      quad        = addr[ADDR_BITS-1 -: 2];
      quarter_pos = addr[QUARTER_BITS-1:0];
      quarter_idx = quad[0] ? (QUARTER_BITS'(0) - quarter_pos) : quarter_pos;
      is_peak     = quad[0] && (quarter_pos == '0);
      sine_mag    = is_peak ? SINE_PEAK : SINE_QUARTER[quarter_idx];
      neg1_in     = adv.s1_load ? quad[1] : neg1_ff;
      sine1_in    = adv.s1_load ? sine_mag : sine1_ff;
   end

   // scale by amplitude, truncate toward zero on the magnitude
   always_comb begin
      product    = (2*SINE_MAG_BITS)'(sine1_ff) * (2*SINE_MAG_BITS)'(amplitude);
      neg2_in    = adv.s2_load ? neg1_ff : neg2_ff;
      scaled2_in = adv.s2_load ? product[2*SINE_MAG_BITS-1 -: SINE_MAG_BITS] : scaled2_ff;
   end

   always_ff @(posedge clock) begin
      neg1_ff    <= neg1_in;
      sine1_ff   <= sine1_in;
      neg2_ff    <= neg2_in;
      scaled2_ff <= scaled2_in;
   end

   assign tone_sample = neg2_ff ? -$signed({1'b0, scaled2_ff})
                                :  $signed({1'b0, scaled2_ff});

endmodule
`default_nettype wire
